// ===== src/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted minimum priority queue
// Operation and status codes, storage sizes, cell control type and value
// width conversion helpers.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // operation codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift_in;   // insert: cells at or past the slot move right
      logic shift_out;  // pop: each cell takes its right neighbor, the last keeps its own
   } cell_ctrl_type;

   // 32-bit input to stored width (sign extend or wrap)
   function automatic logic signed [VALUE_WIDTH-1:0] to_store(
      input logic signed [31:0] x);
      return VALUE_WIDTH'(x);
   endfunction

   // stored width back to 32 bits (sign extend or keep low bits)
   function automatic logic signed [31:0] to_port(
      input logic signed [VALUE_WIDTH-1:0] x);
      return 32'(x);
   endfunction

endpackage
`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted array
// Holds one value, compares it against the broadcast insert value and
// takes a value from its left or right neighbor on insert or pop.
// ----------------------------------------------------------------------------
module spq_cell (
   input  wire logic                                   clock,
   input  wire spq_pkg::cell_ctrl_type                 ctrl,
   input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] new_value,
   input  wire logic                                   occupied,
   input  wire logic                                   left_lt,
   input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] left_value,
   input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] right_value,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0]      value,
   output logic                                        lt
);
   import spq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   // strictly less: equal stored values let the new one go ahead
   assign lt    = occupied && (value_ff < new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      priority if (ctrl.shift_in) begin
         if (!lt) begin
            value_in = left_lt ? new_value : left_value;
         end
      end else if (ctrl.shift_out) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// ===== src/sorted_min_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue: bounded min priority queue as a row of cells
// The result is registered: it is valid in the output register in the cycle after the item is accepted.
// Throughput: 1 item per cycle while rsp_ready is high; every cell compares
//   and shifts in parallel, so the whole cell row updates at once.
// Reset: count and result valid are cleared; stored values stay undefined
//   and are never read before written (no clearing pass).
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_func,
   input  wire logic signed [31:0]                 req_item_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [31:0]                      rsp_popped_value,
   output logic [1:0]                              rsp_status,
   output logic [spq_pkg::COUNT_WIDTH-1:0]         rsp_entry_count,
   output logic                                    rsp_queue_empty
);
   import spq_pkg::*;

   // ---- occupancy ---------------------------------------------------------
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   // ---- result register ---------------------------------------------------
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic signed [31:0]     popped_ff;
   logic signed [31:0]     popped_in;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;

   // ---- cell row wiring ---------------------------------------------------
   logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic                          cell_lt    [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] new_value;
   cell_ctrl_type                 ctrl;

   logic accept;
   logic is_full;
   logic no_entries;

   // An item is taken whenever the result register is free or draining;
   // nothing is taken while reset is held.
   assign req_ready  = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign is_full    = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign no_entries = (count_ff == '0);
   assign new_value  = to_store(req_item_value);

   // Decode the item into a shift command plus next count and result.
   always_comb begin
      ctrl.shift_in  = 1'b0;
      ctrl.shift_out = 1'b0;
      count_in       = count_ff;
      popped_in      = '0;
      status_in      = STATUS_OK;
      unique case (req_func)
         FUNC_INSERT: begin
            if (is_full) begin
               status_in = STATUS_FULL;  // dropped, queue untouched
            end else begin
               ctrl.shift_in = accept;
               count_in      = count_ff + 1'b1;
            end
         end
         FUNC_POP: begin
            if (no_entries) begin
               popped_in = -32'sd1;
               status_in = STATUS_POP_EMPTY;
            end else begin
               ctrl.shift_out = accept;
               popped_in      = to_port(cell_value[0]);
               count_in       = count_ff - 1'b1;
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
            // unused code: no change, ok status
         end
      endcase
   end

   // Cell i is live when i is below the count. Cell 0 sees a "less" on its
   // left so an insert at the head lands there; the last cell pulls its own
   // value on pop (that slot becomes unused anyway).
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          left_lt;
      logic signed [VALUE_WIDTH-1:0] left_value;
      logic signed [VALUE_WIDTH-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_value = new_value;
      end else begin : g_body
         assign left_lt    = cell_lt[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .occupied    (COUNT_WIDTH'(i) < count_ff),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .lt          (cell_lt[i])
      );
   end

   // result valid: set on accept, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and the count snapshot travel with the result
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff    <= popped_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_queue_empty  = (rsp_count_ff == '0);

   // ---- assertions --------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("entry count above capacity");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= COUNT_WIDTH'(2) |-> cell_value[0] <= cell_value[1])
      else $error("head cells out of order");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_POP_EMPTY |->
         rsp_queue_empty && rsp_popped_value == -32'sd1)
      else $error("empty pop result inconsistent");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_entry_count == COUNT_WIDTH'(CAPACITY))
      else $error("full drop reported below capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_INSERT && !is_full |=>
         count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the queue");

endmodule
`default_nettype wire
